// ----- hdl/xyg_pkg.sv -----
// Package for the XY gesture recorder: payload structs, opcodes, modes,
// register indexes and the controller/datapath command types.
// No dependencies; every other file in hdl/ refers to it by scoped names.
package xyg_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int COORD_BITS  = 12;
  localparam int LEN_BITS    = $clog2(STORE_DEPTH + 1);
  localparam int ADDR_BITS   = 4;
  localparam int DATA_BITS   = 32;

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  // Request opcodes.
  localparam logic [2:0] OP_MOVE    = 3'd0;
  localparam logic [2:0] OP_PRESS   = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_CLOCK   = 3'd3;
  localparam logic [2:0] OP_RESET   = 3'd4;

  // Operating modes as reported on current_mode.
  localparam logic [1:0] MODE_PLAY  = 2'd0;
  localparam logic [1:0] MODE_REC   = 2'd1;
  localparam logic [1:0] MODE_PUNCH = 2'd2;

  // Configuration register indexes (byte address divided by four).
  localparam logic [1:0] REG_RETRIGGER = 2'd0;
  localparam logic [1:0] REG_PUNCH     = 2'd1;
  localparam logic [1:0] REG_CLOCK     = 2'd2;

  typedef struct packed {
    logic [2:0]            opcode;
    logic [COORD_BITS-1:0] x_position;
    logic [COORD_BITS-1:0] y_position;
  } req_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x_voltage;
    logic [COORD_BITS-1:0] y_voltage;
    logic [1:0]            current_mode;
    logic [LEN_BITS-1:0]   recorded_length;
    logic                  store_full;
  } rsp_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  typedef struct packed {
    logic retrigger_loop;
    logic punch_enable;
    logic clock_connected;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic need_read;
  } stat_t;

  // Output drive: X passes straight, Y is flipped so that the top is full scale.
  function automatic point_t drive_point(point_t p);
    point_t d;
    d.x = p.x;
    d.y = COORD_MAX - p.y;
    return d;
  endfunction

endpackage

// ----- hdl/xyg_regs.sv -----
// Configuration register bank behind the APB-style port.
// Depends on xyg_pkg for the register indexes and the cfg_t struct.
module xyg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xyg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [xyg_pkg::DATA_BITS-1:0] pwdata,
  output logic [xyg_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready,
  output xyg_pkg::cfg_t                 cfg
);

  logic       wr_en;
  logic [1:0] reg_index;
  logic       rd_bit;

  assign pready    = 1'b1;
  assign reg_index = paddr[3:2];
  assign wr_en     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retrigger_loop  <= 1'b1;
      cfg.punch_enable    <= 1'b0;
      cfg.clock_connected <= 1'b1;
    end else if (wr_en) begin
      unique case (reg_index)
        xyg_pkg::REG_RETRIGGER: cfg.retrigger_loop  <= pwdata[0];
        xyg_pkg::REG_PUNCH:     cfg.punch_enable    <= pwdata[0];
        xyg_pkg::REG_CLOCK:     cfg.clock_connected <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_index)
      xyg_pkg::REG_RETRIGGER: rd_bit = cfg.retrigger_loop;
      xyg_pkg::REG_PUNCH:     rd_bit = cfg.punch_enable;
      xyg_pkg::REG_CLOCK:     rd_bit = cfg.clock_connected;
      default:                rd_bit = 1'b0;
    endcase
  end

  assign prdata = {{(xyg_pkg::DATA_BITS-1){1'b0}}, rd_bit};

endmodule

// ----- hdl/xyg_ctrl.sv -----
// Controller for the gesture recorder: request/response handshake and the
// wait state for a point memory read. Depends on xyg_pkg (cmd_t, stat_t).
module xyg_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  input  xyg_pkg::stat_t stat,
  output xyg_pkg::cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_t;

  state_t state;
  state_t state_next;
  logic   ready_int;

  always_comb begin
    state_next = state;
    ready_int  = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        // The response register may be refilled in the cycle it is emptied.
        ready_int  = !rsp_valid || rsp_ready;
        cmd.accept = req_valid && ready_int;
        if (cmd.accept) begin
          if (stat.need_read) begin
            state_next = ST_READ;
          end else begin
            cmd.load_out = 1'b1;
          end
        end
      end
      ST_READ: begin
        cmd.finish   = 1'b1;
        cmd.load_out = 1'b1;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign req_ready = ready_int;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hdl/xyg_dp.sv -----
// Datapath for the gesture recorder: point memory, index and count
// registers, mode, held outputs and the response register.
// Depends on xyg_pkg; driven by xyg_ctrl through cmd_t.
module xyg_dp (
  input  logic           clk,
  input  logic           rst,
  input  xyg_pkg::cmd_t  cmd,
  input  xyg_pkg::req_t  req,
  input  xyg_pkg::cfg_t  cfg,
  output xyg_pkg::stat_t stat,
  output xyg_pkg::rsp_t  rsp
);

  localparam int AW = $clog2(xyg_pkg::STORE_DEPTH);
  localparam int CW = xyg_pkg::LEN_BITS;
  localparam logic [CW-1:0] DEPTH_C = CW'(xyg_pkg::STORE_DEPTH);

  xyg_pkg::point_t mem [xyg_pkg::STORE_DEPTH];
  xyg_pkg::point_t rd_data;

  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic [CW-1:0]   idx;
  logic [CW-1:0]   idx_next;
  logic [1:0]      mode;
  logic [1:0]      mode_next;
  logic            full;
  logic            full_next;
  xyg_pkg::point_t cur;
  xyg_pkg::point_t cur_next;
  xyg_pkg::point_t held;
  xyg_pkg::point_t held_next;

  xyg_pkg::point_t pos;
  logic [CW-1:0]   idx_w;
  logic            idx_ok;
  logic            play_read;
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic            rd_en;

  assign pos.x = req.x_position;
  assign pos.y = req.y_position;

  // Index after the retrigger wrap; only meaningful with a nonempty store.
  assign idx_w  = (cfg.retrigger_loop && idx >= count) ? '0 : idx;
  assign idx_ok = (count != '0) && (idx_w < count);

  assign play_read = (req.opcode == xyg_pkg::OP_CLOCK) && cfg.clock_connected &&
                     (mode == xyg_pkg::MODE_PLAY) && idx_ok;
  assign stat.need_read = play_read;

  always_comb begin
    count_next = count;
    idx_next   = idx;
    mode_next  = mode;
    full_next  = full;
    cur_next   = cur;
    held_next  = held;
    wr_en      = 1'b0;
    wr_addr    = count[AW-1:0];
    rd_en      = 1'b0;
    if (cmd.accept) begin
      case (req.opcode)
        xyg_pkg::OP_MOVE: begin
          cur_next = pos;
        end
        xyg_pkg::OP_PRESS: begin
          cur_next = pos;
          if (cfg.punch_enable) begin
            mode_next = xyg_pkg::MODE_PUNCH;
          end else begin
            count_next = '0;
            full_next  = 1'b0;
            mode_next  = xyg_pkg::MODE_REC;
          end
        end
        xyg_pkg::OP_RELEASE: begin
          cur_next = pos;
          if (!cfg.punch_enable) begin
            idx_next = '0;
          end
          mode_next = xyg_pkg::MODE_PLAY;
        end
        xyg_pkg::OP_CLOCK: begin
          if (cfg.clock_connected) begin
            if (mode == xyg_pkg::MODE_REC) begin
              held_next = xyg_pkg::drive_point(cur);
              if (count < DEPTH_C) begin
                wr_en      = 1'b1;
                wr_addr    = count[AW-1:0];
                count_next = count + CW'(1);
              end else begin
                full_next = 1'b1;
              end
            end else if (count != '0) begin
              idx_next = idx_w;
              if (idx_ok) begin
                case (mode)
                  xyg_pkg::MODE_PUNCH: begin
                    wr_en     = 1'b1;
                    wr_addr   = idx_w[AW-1:0];
                    held_next = xyg_pkg::drive_point(cur);
                    idx_next  = idx_w + CW'(1);
                  end
                  xyg_pkg::MODE_PLAY: begin
                    // The point comes from the registered read port; see the finish step.
                    rd_en    = 1'b1;
                    idx_next = idx_w + CW'(1);
                  end
                  default: ;
                endcase
              end
            end
          end
        end
        xyg_pkg::OP_RESET: begin
          idx_next = '0;
        end
        default: ;
      endcase
      if (!cfg.clock_connected) begin
        held_next = xyg_pkg::drive_point(cur_next);
      end
    end
    if (cmd.finish) begin
      cur_next  = rd_data;
      held_next = xyg_pkg::drive_point(rd_data);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cur;
    end
    if (rd_en) begin
      rd_data <= mem[idx_w[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      idx   <= '0;
      mode  <= xyg_pkg::MODE_PLAY;
      full  <= 1'b0;
      cur   <= '0;
      held  <= '0;
    end else begin
      count <= count_next;
      idx   <= idx_next;
      mode  <= mode_next;
      full  <= full_next;
      cur   <= cur_next;
      held  <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      rsp.x_voltage       <= held_next.x;
      rsp.y_voltage       <= held_next.y;
      rsp.current_mode    <= mode_next;
      rsp.recorded_length <= count_next;
      rsp.store_full      <= full_next;
    end
  end

endmodule

// ----- hdl/xy_gesture_record_playback.sv -----
// XY gesture recorder and player: a request channel takes position moves,
// button press and release, clock edges and reset edges; a response channel
// returns the held X/Y output codes, the mode, the recorded length and the
// store-full flag, one response per request. Both channels use valid/ready.
// Response: valid the cycle after its request is accepted, except for a
// clock edge in playback mode that reads a point, which first waits on the
// registered read port of the point memory.
// Throughput: one request per cycle, except after a playback clock edge
// that reads a point. A request is taken while the response register is
// empty or being emptied in the same cycle; while the receiver stalls, the
// response holds and no further request is accepted.
// Reset (rst, synchronous) clears mode, count, index, flag, current point
// and held outputs, and loads the registers with retrigger_loop = 1,
// punch_enable = 0, clock_connected = 1. The point memory keeps its
// contents; only entries below the recorded length are ever read.
// Configuration: APB-style writes at byte address 4 * register index.
module xy_gesture_record_playback (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  xyg_pkg::req_t                 req,
  output logic                          rsp_valid,
  input  logic                          rsp_ready,
  output xyg_pkg::rsp_t                 rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [xyg_pkg::ADDR_BITS-1:0] paddr,
  input  logic [xyg_pkg::DATA_BITS-1:0] pwdata,
  output logic [xyg_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  xyg_pkg::cfg_t  cfg;
  xyg_pkg::cmd_t  cmd;
  xyg_pkg::stat_t stat;

  xyg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  xyg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  xyg_dp u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .req  (req),
    .cfg  (cfg),
    .stat (stat),
    .rsp  (rsp)
  );

endmodule
